// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/bfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Block frame decoder package
// Shared constants and types for the block frame decoder.
// ----------------------------------------------------------------------------
package bfd_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [3:0] PH_FLAGS  = 4'd0;
    localparam logic [3:0] PH_CNT_LO = 4'd1;
    localparam logic [3:0] PH_CNT_HI = 4'd2;
    localparam logic [3:0] PH_OFFSET = 4'd3;
    localparam logic [3:0] PH_BLOCKS = 4'd4;
    localparam logic [3:0] PH_DATA   = 4'd5;

    localparam logic [1:0] KIND_SOLID = 2'd0;
    localparam logic [1:0] KIND_TWO8  = 2'd1;
    localparam logic [1:0] KIND_RAW   = 2'd2;

    localparam int BAD_COUNT = 160;

    localparam logic       CFG_WIDTH_IDX  = 1'b0;
    localparam logic       CFG_HEIGHT_IDX = 1'b1;

    // Work handed from the parser to the pixel emitter.
    typedef struct packed {
        logic        err;       // one error result
        logic        raw;       // one raw pixel result
        logic        pattern;   // sixteen pattern results
        logic [15:0] x;
        logic [15:0] y;
        logic [3:0]  pos;       // raw pixel position in block
        logic [15:0] pat;
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic        last_frame;
    } bfd_job_t;

    typedef struct packed {
        logic        pixel_valid;
        logic [19:0] pixel_index;
        logic [7:0]  pixel_value;
        logic        out_of_bounds;
        logic        frame_error;
        logic        run_last;
    } bfd_res_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } bfd_in_t;

endpackage

// ----- hw/rtl/bfd_stream_if.sv -----
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying a payload of a given type.
// ----------------------------------------------------------------------------
interface bfd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bfd_parser.sv -----
// ----------------------------------------------------------------------------
// Block frame parser
// Walks the byte stream and issues pixel jobs to the emitter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bfd_parser
    import bfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  bfd_in_t  in_data,
    output logic     in_ready,
    output logic     job_valid,
    output bfd_job_t job,
    input  logic     job_take
);
    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  flags_reg, flags_next;
    logic [1:0]  kind_reg, kind_next;
    logic [9:0]  chunks_reg, chunks_next;
    logic [7:0]  blocks_reg, blocks_next;
    logic [15:0] x_reg, x_next, y_reg, y_next;
    logic [3:0]  bib_reg, bib_next;
    logic [7:0]  c0_reg, c0_next, c1_reg, c1_next, low_reg, low_next;
    logic        failed_reg, failed_next;
    logic        jv_reg;
    bfd_job_t    job_reg, job_next;
    logic        take;
    logic [7:0]  b;
    logic [15:0] raw, mag;
    logic [16:0] xsum;
    logic [16:0] ysum;
    logic [2:0]  seek_k;
    logic        seek_found;
    logic        do_seek, seek_from_start;

    assign in_ready  = !jv_reg || job_take;
    assign take      = in_valid && in_ready;
    assign job_valid = jv_reg;
    assign job       = job_reg;
    assign b         = in_data.data_byte;
    assign raw       = {b, low_reg};
    assign mag       = raw[15] ? 16'(16'h0 - raw) : raw;

    // Next-kind search over the pending flags.
    always_comb
    begin
        logic [3:0] fl;
        fl = (phase_reg == PH_FLAGS) ? b[3:0] : flags_reg;
        seek_found = 1'b0;
        seek_k = 3'd0;
        for (int k = 3; k >= 0; k--)
        begin
            if (fl[k] && (seek_from_start || 3'(k) > {1'b0, kind_reg}))
            begin
                seek_found = 1'b1;
                seek_k = 3'(k);
            end
        end
    end

    always_comb
    begin
        logic [7:0] units;
        logic       endblk, endchk;
        phase_next  = phase_reg;
        flags_next  = flags_reg;
        kind_next   = kind_reg;
        chunks_next = chunks_reg;
        blocks_next = blocks_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        bib_next    = bib_reg;
        c0_next     = c0_reg;
        c1_next     = c1_reg;
        low_next    = low_reg;
        failed_next = failed_reg;
        job_next    = '0;
        job_next.y  = y_reg;
        job_next.c0 = c0_reg;
        job_next.c1 = c1_reg;
        job_next.x  = x_reg;
        job_next.last_frame = in_data.frame_last;
        units  = 8'd0;
        endblk = 1'b0;
        endchk = 1'b0;
        do_seek = 1'b0;
        seek_from_start = (phase_reg == PH_FLAGS);
        if (!failed_reg)
        begin
            case (phase_reg)
                PH_FLAGS:
                begin
                    flags_next = b[3:0];
                    do_seek = 1'b1;
                end
                PH_CNT_LO:
                begin
                    low_next   = b;
                    phase_next = PH_CNT_HI;
                end
                PH_CNT_HI:
                begin
                    if (raw[15] && raw == 16'h8000 || mag >= 16'(BAD_COUNT))
                    begin
                        failed_next  = 1'b1;
                        job_next.err = 1'b1;
                    end
                    else if (mag == 16'd0)
                    begin
                        chunks_next = 10'd0;
                        do_seek = 1'b1;
                    end
                    else
                    begin
                        chunks_next = 10'(mag);
                        phase_next  = raw[15] ? PH_OFFSET : PH_BLOCKS;
                    end
                end
                PH_OFFSET:
                begin
                    units = b;
                    if (chunks_reg != 10'd0)
                        chunks_next = chunks_reg - 10'd1;
                    phase_next = PH_BLOCKS;
                end
                PH_BLOCKS:
                begin
                    blocks_next = b;
                    bib_next = 4'd0;
                    if (b == 8'd0)
                        endchk = 1'b1;
                    else
                        phase_next = PH_DATA;
                end
                default:
                begin
                    case (kind_reg)
                        KIND_SOLID:
                        begin
                            job_next.c0 = b;
                            job_next.c1 = b;
                            c0_next = b;
                            c1_next = b;
                            job_next.pattern = 1'b1;
                            endblk = 1'b1;
                        end
                        KIND_TWO8:
                        begin
                            case (bib_reg)
                                4'd0:
                                begin
                                    c0_next = b;
                                    bib_next = 4'd1;
                                end
                                4'd1:
                                begin
                                    c1_next = b;
                                    bib_next = 4'd2;
                                end
                                4'd2:
                                begin
                                    low_next = b;
                                    bib_next = 4'd3;
                                end
                                default:
                                begin
                                    job_next.pattern = 1'b1;
                                    job_next.pat = {b, low_reg};
                                    endblk = 1'b1;
                                end
                            endcase
                        end
                        KIND_RAW:
                        begin
                            job_next.raw = 1'b1;
                            job_next.pos = bib_reg;
                            job_next.c0  = b;
                            if (bib_reg == 4'd15)
                                endblk = 1'b1;
                            else
                                bib_next = bib_reg + 4'd1;
                        end
                        default:
                        begin
                            case (bib_reg)
                                4'd0:
                                begin
                                    c0_next = {4'd0, b[3:0]};
                                    c1_next = {4'd0, b[7:4]};
                                    bib_next = 4'd1;
                                end
                                4'd1:
                                begin
                                    low_next = b;
                                    bib_next = 4'd2;
                                end
                                default:
                                begin
                                    job_next.pattern = 1'b1;
                                    job_next.pat = {b, low_reg};
                                    endblk = 1'b1;
                                end
                            endcase
                        end
                    endcase
                end
            endcase
            if (endblk)
            begin
                units = 8'd1;
                bib_next = 4'd0;
                blocks_next = blocks_reg - 8'd1;
                if (blocks_reg == 8'd1)
                    endchk = 1'b1;
            end
            xsum = {1'b0, x_reg} + {7'd0, units, 2'b00};
            x_next = xsum[16] ? 16'hFFFF : xsum[15:0];
            if (endchk)
            begin
                if (chunks_reg <= 10'd1)
                begin
                    chunks_next = 10'd0;
                    do_seek = 1'b1;
                end
                else
                begin
                    chunks_next = chunks_reg - 10'd1;
                    phase_next = PH_OFFSET;
                end
            end
            if (do_seek)
            begin
                if (seek_found)
                begin
                    kind_next  = seek_k[1:0];
                    x_next     = 16'd0;
                    phase_next = PH_CNT_LO;
                end
                else
                begin
                    kind_next  = 2'd0;
                    flags_next = 4'd0;
                    ysum = {1'b0, y_reg} + 17'd4;
                    y_next = ysum[16] ? 16'hFFFF : ysum[15:0];
                    phase_next = PH_FLAGS;
                end
            end
        end
        else
        begin
            xsum = 17'd0;
        end
        ysum = {1'b0, y_reg} + 17'd4;
    end

    // Parser state and job register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FLAGS;
            flags_reg  <= '0;
            kind_reg   <= '0;
            chunks_reg <= '0;
            blocks_reg <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            bib_reg    <= '0;
            c0_reg     <= '0;
            c1_reg     <= '0;
            low_reg    <= '0;
            failed_reg <= 1'b0;
            jv_reg     <= 1'b0;
        end
        else
        begin
            if (job_take)
                jv_reg <= 1'b0;
            if (take)
            begin
                jv_reg <= job_next.err || job_next.raw || job_next.pattern;
                if (in_data.frame_last)
                begin
                    phase_reg  <= PH_FLAGS;
                    flags_reg  <= '0;
                    kind_reg   <= '0;
                    chunks_reg <= '0;
                    blocks_reg <= '0;
                    x_reg      <= '0;
                    y_reg      <= '0;
                    bib_reg    <= '0;
                    c0_reg     <= '0;
                    c1_reg     <= '0;
                    low_reg    <= '0;
                    failed_reg <= 1'b0;
                end
                else
                begin
                    phase_reg  <= phase_next;
                    flags_reg  <= flags_next;
                    kind_reg   <= kind_next;
                    chunks_reg <= chunks_next;
                    blocks_reg <= blocks_next;
                    x_reg      <= x_next;
                    y_reg      <= y_next;
                    bib_reg    <= bib_next;
                    c0_reg     <= c0_next;
                    c1_reg     <= c1_next;
                    low_reg    <= low_next;
                    failed_reg <= failed_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= job_next;
    end

    `ASSERT_IMPLIES(a_phase_legal, clk, rst_n, 1'b1, phase_reg <= PH_DATA)
    `ASSERT_IMPLIES(a_one_kind, clk, rst_n, jv_reg,
        $onehot({job_reg.err, job_reg.raw, job_reg.pattern}))
    `ASSERT_NEXT(a_fail_silent, clk, rst_n, failed_reg && !take, failed_reg)
endmodule

// ----- hw/rtl/bfd_emitter.sv -----
// ----------------------------------------------------------------------------
// Pixel emitter
// Expands one job into one or sixteen registered pixel results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bfd_emitter
    import bfd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [10:0] frame_width,
    input  logic [10:0] frame_height,
    input  logic      job_valid,
    input  bfd_job_t  job,
    output logic      job_take,
    output logic      res_valid,
    output bfd_res_t  res,
    input  logic      res_ready
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = (WW > 11) ? WW : 11;
    localparam int YW = (HW > 11) ? HW : 11;

    logic [3:0]  cnt_reg;
    logic        rv_reg;
    bfd_res_t    res_reg;
    logic        adv;
    logic        single, lastp;
    logic [3:0]  p;
    logic [17:0] px, py;
    logic [XW-1:0] w;
    logic [YW-1:0] h;
    logic [39:0] prod;
    bfd_res_t    r;

    assign w = ({{(XW-11){1'b0}}, frame_width} > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH)
               : {{(XW-11){1'b0}}, frame_width};
    assign h = ({{(YW-11){1'b0}}, frame_height} > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT)
               : {{(YW-11){1'b0}}, frame_height};

    assign adv      = !rv_reg || res_ready;
    assign single   = job.err || job.raw;
    assign lastp    = single || cnt_reg == 4'd15;
    assign job_take = job_valid && adv && lastp;
    assign p        = job.raw ? job.pos : cnt_reg;
    assign px       = 18'(job.x) + 18'(p[1:0]);
    assign py       = 18'(job.y) + 18'(p[3:2]);
    assign prod     = 40'(py) * 40'(w);

    // Pixel result for the current position.
    always_comb
    begin
        r = '0;
        r.run_last = lastp;
        if (job.err)
            r.frame_error = 1'b1;
        else if (px < 18'(w) && py < 18'(h))
        begin
            r.pixel_valid = 1'b1;
            r.pixel_index = 20'(prod + 40'(px));
            r.pixel_value = (job.raw || !job.pat[cnt_reg]) ? job.c0 : job.c1;
        end
        else
            r.out_of_bounds = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rv_reg  <= 1'b0;
        end
        else if (adv)
        begin
            rv_reg <= job_valid;
            if (job_valid && !single)
                cnt_reg <= cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && job_valid)
            res_reg <= r;
    end

    assign res_valid = rv_reg;
    assign res       = res_reg;

    `ASSERT_IMPLIES(a_oob_excl, clk, rst_n, rv_reg,
        !(res_reg.pixel_valid && res_reg.out_of_bounds))
    `ASSERT_IMPLIES(a_cnt_idle, clk, rst_n, !job_valid, cnt_reg == 4'd0)
    `ASSERT_NEXT(a_hold, clk, rst_n, rv_reg && !res_ready, rv_reg && $stable(res_reg))
endmodule

// ----- hw/rtl/block_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// Block frame decoder
// Decodes a 4x4-block compressed byte stream into pixel write results.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  in_ch     sink       data_byte, frame_last
//  out_ch    source     pixel_valid, pixel_index, pixel_value,
//                       out_of_bounds, frame_error, run_last
//
// A byte is parsed into a job register; the emitter sends one result per
// cycle unless the output stalls: sixteen for a pattern block, one for a
// raw pixel or an error. The next byte waits for the job's last result.
// Reset clears all parse state; width and height return to 320 and 240.
// Output stalls hold the result register and back up to the input.
module block_frame_decoder
    import bfd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    bfd_stream_if.sink   in_ch,
    bfd_stream_if.source out_ch
);
    logic [10:0] width_reg, height_reg;
    logic        job_valid, job_take;
    bfd_job_t    job;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd320;
            height_reg <= 11'd240;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH_IDX)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
        end
    end

    bfd_parser u_parser (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_data(in_ch.data), .in_ready(in_ch.ready),
        .job_valid(job_valid), .job(job), .job_take(job_take)
    );

    bfd_emitter #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_emit (
        .clk(clk), .rst_n(rst_n),
        .frame_width(width_reg), .frame_height(height_reg),
        .job_valid(job_valid), .job(job), .job_take(job_take),
        .res_valid(out_ch.valid), .res(out_ch.data), .res_ready(out_ch.ready)
    );
endmodule

// ----- bench/bfd_pixel_checker.sv -----
// ----------------------------------------------------------------------------
// Block frame decoder pixel checker
// Watches both channels of the block frame decoder, works out the pixel
// writes that each accepted byte should cause and compares them in order.
// ----------------------------------------------------------------------------
module bfd_pixel_checker
    import bfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  bfd_in_t     in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  bfd_res_t    out_data,
    output int          fail_count,
    output int          pending_pixels
);

    timeunit 1ns;
    timeprecision 1ps;

    // Decoder state mirrored at the block's widths.
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [3:0]  phase;
    logic [3:0]  flags;
    logic [1:0]  kind;
    logic [9:0]  chunks;
    logic [7:0]  blocks;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [3:0]  blk_pos;
    logic [7:0]  col_a;
    logic [7:0]  col_b;
    logic [7:0]  low_byte;
    logic        failed;

    bfd_res_t expected_pixels[$];

    assign pending_pixels = expected_pixels.size();

    function automatic void clear_decoder();
        phase = PH_FLAGS;
        flags = '0;
        kind = '0;
        chunks = '0;
        blocks = '0;
        cur_x = '0;
        cur_y = '0;
        blk_pos = '0;
        col_a = '0;
        col_b = '0;
        low_byte = '0;
        failed = 1'b0;
    endfunction

    function automatic void step_x(int units);
        int v;
        v = cur_x + units * 4;
        cur_x = (v > 16'hFFFF) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic void push_pixel(int px, int py, logic [7:0] val);
        bfd_res_t r;
        int w;
        int h;
        w = (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
        h = (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg;
        r = '0;
        if (px < w && py < h)
        begin
            r.pixel_valid = 1'b1;
            r.pixel_index = 20'(py * w + px);
            r.pixel_value = val;
        end
        else
        begin
            r.out_of_bounds = 1'b1;
        end
        expected_pixels.push_back(r);
    endfunction

    // Move to the next selected kind, or close the row of blocks.
    function automatic void next_kind(int start);
        int v;
        for (int k = start; k < 4; k++)
        begin
            if (flags[k])
            begin
                kind = 2'(k);
                cur_x = '0;
                phase = PH_CNT_LO;
                return;
            end
        end
        kind = '0;
        flags = '0;
        v = cur_y + 4;
        cur_y = (v > 16'hFFFF) ? 16'hFFFF : 16'(v);
        phase = PH_FLAGS;
    endfunction

    function automatic void close_chunk();
        if (chunks <= 1)
        begin
            chunks = '0;
            next_kind(int'(kind) + 1);
        end
        else
        begin
            chunks = chunks - 1;
            phase = PH_OFFSET;
        end
    endfunction

    function automatic void close_block();
        step_x(1);
        blk_pos = '0;
        blocks = blocks - 1;
        if (blocks == 0)
            close_chunk();
    endfunction

    function automatic void push_block(logic [15:0] pat);
        for (int i = 0; i < 16; i++)
            push_pixel(cur_x + (i % 4), cur_y + (i / 4), pat[i] ? col_b : col_a);
    endfunction

    // Work out the pixel writes caused by one stream byte.
    function automatic void decode_byte(logic [7:0] b, logic last);
        int start_size;
        logic [15:0] raw;
        int mag;
        bfd_res_t r;
        start_size = expected_pixels.size();
        if (!failed)
        begin
            case (phase)
                PH_FLAGS:
                begin
                    flags = b[3:0];
                    next_kind(0);
                end
                PH_CNT_LO:
                begin
                    low_byte = b;
                    phase = PH_CNT_HI;
                end
                PH_CNT_HI:
                begin
                    raw = {b, low_byte};
                    mag = raw[15] ? (65536 - raw) : raw;
                    if (mag >= BAD_COUNT)
                    begin
                        failed = 1'b1;
                        r = '0;
                        r.frame_error = 1'b1;
                        expected_pixels.push_back(r);
                    end
                    else if (mag == 0)
                    begin
                        chunks = '0;
                        next_kind(int'(kind) + 1);
                    end
                    else
                    begin
                        chunks = 10'(mag);
                        phase = raw[15] ? PH_OFFSET : PH_BLOCKS;
                    end
                end
                PH_OFFSET:
                begin
                    step_x(b);
                    if (chunks > 0)
                        chunks = chunks - 1;
                    phase = PH_BLOCKS;
                end
                PH_BLOCKS:
                begin
                    blocks = b;
                    blk_pos = '0;
                    if (b == 0)
                        close_chunk();
                    else
                        phase = PH_DATA;
                end
                default:
                begin
                    case (kind)
                        KIND_SOLID:
                        begin
                            col_a = b;
                            col_b = b;
                            push_block('0);
                            close_block();
                        end
                        KIND_TWO8:
                        begin
                            if (blk_pos == 0)
                                col_a = b;
                            else if (blk_pos == 1)
                                col_b = b;
                            else if (blk_pos == 2)
                                low_byte = b;
                            if (blk_pos < 3)
                                blk_pos = blk_pos + 1;
                            else
                            begin
                                push_block({b, low_byte});
                                close_block();
                            end
                        end
                        KIND_RAW:
                        begin
                            push_pixel(int'(cur_x) + int'(blk_pos[1:0]),
                                       int'(cur_y) + int'(blk_pos[3:2]), b);
                            if (blk_pos == 15)
                                close_block();
                            else
                                blk_pos = blk_pos + 1;
                        end
                        default:
                        begin
                            if (blk_pos == 0)
                            begin
                                col_a = {4'h0, b[3:0]};
                                col_b = {4'h0, b[7:4]};
                                blk_pos = 1;
                            end
                            else if (blk_pos == 1)
                            begin
                                low_byte = b;
                                blk_pos = 2;
                            end
                            else
                            begin
                                push_block({b, low_byte});
                                close_block();
                            end
                        end
                    endcase
                end
            endcase
        end
        if (expected_pixels.size() > start_size)
            expected_pixels[$].run_last = 1'b1;
        if (last)
            clear_decoder();
    endfunction

    // Mirror configuration, predict on input transactions, check outputs.
    always @(posedge clk or negedge rst_n)
    begin
        bfd_res_t exp_r;
        if (!rst_n)
        begin
            width_reg <= 11'd320;
            height_reg <= 11'd240;
            clear_decoder();
            expected_pixels.delete();
            fail_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected result transaction %p", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_pixels.pop_front();
                    if (exp_r !== out_data)
                    begin
                        if (fail_count < 10)
                            $display("Mismatch: expected %p, got %p", exp_r, out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                decode_byte(in_data.data_byte, in_data.frame_last);
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH_IDX)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
            end
        end
    end

endmodule

// ----- bench/block_frame_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// Block frame decoder testbench
// Drives directed and random compressed frames through the decoder under
// random bursts and output stalls, over several frame sizes, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module block_frame_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bfd_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [10:0] cfg_data;
    int          fail_count;
    int          pending_pixels;
    int          idle_cycles;
    int          burst_left;
    int          stall_phase;
    logic [7:0]  frame_bytes[$];

    bfd_stream_if #(.T(bfd_in_t))  in_ch();
    bfd_stream_if #(.T(bfd_res_t)) out_ch();

    block_frame_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    bfd_pixel_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .in_data        (in_ch.data),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_data       (out_ch.data),
        .fail_count     (fail_count),
        .pending_pixels (pending_pixels)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver stalls: stretches of free flow, then a stall pattern.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if ((stall_phase % 400) < 100)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Send one byte, with burst gaps from the sender.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data <= '{data_byte: b, frame_last: last};
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (burst_left == 0)
            in_ch.valid <= 1'b0;
    endtask

    task automatic send_frame();
        logic [7:0] nb;
        while (frame_bytes.size() > 0)
        begin
            nb = frame_bytes.pop_front();
            send_byte(nb, frame_bytes.size() == 0);
        end
        in_ch.valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending_pixels != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [10:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_count(input int cnt);
        frame_bytes.push_back(8'(cnt));
        frame_bytes.push_back(8'(cnt >> 8));
    endtask

    // Random block data for one block of the given kind.
    task automatic add_block(input int k);
        int n;
        n = (k == 0) ? 1 : (k == 1) ? 4 : (k == 2) ? 16 : 3;
        repeat (n) frame_bytes.push_back(8'($urandom));
    endtask

    // A well-formed kind section with random chunks and offsets.
    task automatic add_kind(input int k);
        int chunks;
        logic neg;
        int nb;
        chunks = $urandom_range(0, 2);
        neg = $urandom_range(0, 1);
        add_count(neg ? -chunks : chunks);
        for (int c = 0; c < chunks; c++)
        begin
            if (neg || c > 0)
                frame_bytes.push_back(8'($urandom_range(0, 255)));
            nb = ($urandom_range(0, 9) == 0) ? 0 : 1;
            frame_bytes.push_back(8'(nb));
            repeat (nb) add_block(k);
        end
    endtask

    task automatic random_frame();
        logic [3:0] f;
        f = 4'($urandom);
        frame_bytes.push_back({4'($urandom), f});
        for (int k = 0; k < 4; k++)
            if (f[k])
                add_kind(k);
        // Occasional noise or a bad count at the end of the frame.
        case ($urandom_range(0, 5))
            0: repeat ($urandom_range(1, 5)) frame_bytes.push_back(8'($urandom));
            1:
            begin
                frame_bytes.push_back(8'h01);
                add_count($urandom_range(0, 1) ? 160 + $urandom_range(0, 1000)
                                               : -160 - $urandom_range(0, 1000));
                frame_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
        if (frame_bytes.size() == 0)
            frame_bytes.push_back(8'h00);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stall_phase = 0;
        idle_cycles = 0;
        burst_left = 0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: solid block, two-colour pattern, raw block, zero nibble count.
        frame_bytes = '{8'h0F,
                        8'h01, 8'h00, 8'h01, 8'hFF,
                        8'h01, 8'h00, 8'h01, 8'hFF, 8'h00, 8'hFF, 8'hA5,
                        8'h01, 8'h00, 8'h01};
        repeat (16) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'h00);  // zero count for nibble kind
        frame_bytes.push_back(8'h00);
        send_frame();
        // Offset that uses the last chunk, then exact bad count -32768.
        frame_bytes = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h55,
                        8'h01, 8'h00, 8'h80, 8'h12};
        send_frame();
        drain();

        // Extremes of frame size, then random settings.
        for (int s = 0; s < 4; s++)
        begin
            case (s)
                0: begin write_reg(CFG_WIDTH_IDX, 11'd4); write_reg(CFG_HEIGHT_IDX, 11'd4); end
                1: begin write_reg(CFG_WIDTH_IDX, 11'd1024); write_reg(CFG_HEIGHT_IDX, 11'd1024); end
                2: begin write_reg(CFG_WIDTH_IDX, 11'd2047); write_reg(CFG_HEIGHT_IDX, 11'd2047); end
                default:
                begin
                    write_reg(CFG_WIDTH_IDX, 11'($urandom_range(4, 1024)));
                    write_reg(CFG_HEIGHT_IDX, 11'($urandom_range(4, 1024)));
                end
            endcase
            random_frame();
            send_frame();
            // Hold off until every pixel of the phase has arrived.
            drain();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- block_frame_decoder.f -----
+incdir+hw/rtl
hw/rtl/bfd_pkg.sv
hw/rtl/bfd_stream_if.sv
hw/rtl/bfd_parser.sv
hw/rtl/bfd_emitter.sv
hw/rtl/block_frame_decoder.sv
bench/bfd_pixel_checker.sv
bench/block_frame_decoder_tb.sv
